>>> design/lome_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lome_pkg;

    // result kinds carried in m_tuser
    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_RESTED = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    // book side index, equal to the side code of an order on that side
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    // one resting order
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] qty;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH_RD,
        ST_MATCH_CMP,
        ST_STATUS,
        ST_INS_RD,
        ST_INS_CMP
    } state_t;

endpackage

`default_nettype wire

>>> design/lome_book_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lome_book_ram
    import lome_pkg::*;
#(
    parameter int AW = 6
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [2**AW];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/limit_order_matching_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// limit order matching engine, price-time priority, bounded book
// input channel s_*: one beat is one limit order (id, limit price, quantity,
// side in s_tuser). output channel m_*: trade beats, then one status beat
// with m_tlast high; m_tuser gives the result kind.
// each book side sits in one shared memory as a ring, best order at the head.
// steps: accept the order, then per fill a head read followed by compare
// and subtract; matching is over at the read step when the opposite side is
// empty or no quantity is left, or at the compare step when the head does not
// cross; then the status is issued, and when a remainder rests, each resting
// order that has to move back is read and moved one slot, and the new order is
// placed at the front or, after a read, behind an order that stays ahead.
// each fill and each shift loops through the single memory read port.
// s_tready is high only while idle; one order is worked at a time.
// a result waits in the output register; while it waits and m_tready is low
// the engine holds at the next result, so no result is lost.
// reset empties both sides (counts and heads cleared); memory contents
// need no clearing since only entries below a count are read.
module limit_order_matching_engine_unit
    import lome_pkg::*;
#(
    parameter int BOOK_DEPTH = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // order_id, limit_price, quantity
    input  wire logic         s_tuser,   // side
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // buyer_id, seller_id, fill_price, fill_qty
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast    // last
);

    localparam int PW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg  [2];
    logic [CW-1:0] cnt_next [2];
    logic [PW-1:0] head_reg [2];
    logic [PW-1:0] head_next[2];

    logic [31:0] id_reg, id_next;
    logic        side_reg, side_next;
    logic [31:0] lim_reg, lim_next;
    logic [31:0] qty_reg, qty_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [127:0] m_tdata_reg, m_tdata_next;
    logic [1:0]   m_tuser_reg, m_tuser_next;
    logic         m_tlast_reg, m_tlast_next;

    logic         mem_we, mem_re;
    logic [PW:0]  mem_waddr, mem_raddr;
    entry_t       mem_wdata, mem_rdata;

    logic         own, opp, out_free, crosses, ahead, rest;
    logic [31:0]  fill;
    entry_t       new_entry;

    // ring position of a logical slot
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                           input logic [CW-1:0] slot);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(slot);
        if (sum >= (CW+1)'(BOOK_DEPTH))
        begin
            sum = sum - (CW+1)'(BOOK_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    lome_book_ram #(.AW(PW + 1)) u_book (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared compare and subtract unit
    assign own      = side_reg;
    assign opp      = ~side_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign crosses  = (side_reg == SIDE_BID) ? (mem_rdata.price <= lim_reg)
                                             : (mem_rdata.price >= lim_reg);
    assign ahead    = (side_reg == SIDE_BID) ? (mem_rdata.price >= lim_reg)
                                             : (mem_rdata.price <= lim_reg);
    assign fill     = (qty_reg < mem_rdata.qty) ? qty_reg : mem_rdata.qty;
    assign rest     = (qty_reg != 32'd0) && (cnt_reg[own] < DEPTH_C);
    assign new_entry = '{id: id_reg, price: lim_reg, qty: qty_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MATCH_RD;
                end
            end
            ST_MATCH_RD:
            begin
                if (qty_reg == 32'd0 || cnt_reg[opp] == '0)
                begin
                    state_next = ST_STATUS;
                end
                else
                begin
                    state_next = ST_MATCH_CMP;
                end
            end
            ST_MATCH_CMP:
            begin
                if (!crosses)
                begin
                    state_next = ST_STATUS;
                end
                else if (out_free)
                begin
                    state_next = ST_MATCH_RD;
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    state_next = rest ? ST_INS_RD : ST_IDLE;
                end
            end
            ST_INS_RD:
            begin
                state_next = (idx_reg == '0) ? ST_IDLE : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = ahead ? ST_IDLE : ST_INS_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, memory port and output register
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        id_next       = id_reg;
        side_next     = side_reg;
        lim_next      = lim_reg;
        qty_next      = qty_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = {own, phys(head_reg[own], idx_reg)};
        mem_wdata     = new_entry;
        mem_raddr     = {opp, head_reg[opp]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next   = s_tdata[31:0];
                    lim_next  = s_tdata[63:32];
                    qty_next  = s_tdata[95:64];
                    side_next = s_tuser;
                end
            end
            ST_MATCH_RD:
            begin
                mem_re = (qty_reg != 32'd0) && (cnt_reg[opp] != '0);
            end
            ST_MATCH_CMP:
            begin
                if (crosses && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = KIND_TRADE;
                    m_tlast_next  = 1'b0;
                    if (side_reg == SIDE_BID)
                    begin
                        m_tdata_next = {fill, mem_rdata.price, mem_rdata.id, id_reg};
                    end
                    else
                    begin
                        m_tdata_next = {fill, mem_rdata.price, id_reg, mem_rdata.id};
                    end
                    qty_next = qty_reg - fill;
                    if (mem_rdata.qty == fill)
                    begin
                        // resting order filled, pop it
                        cnt_next[opp]  = cnt_reg[opp] - 1'b1;
                        head_next[opp] = (head_reg[opp] == PW'(BOOK_DEPTH - 1))
                                         ? '0 : head_reg[opp] + 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {opp, head_reg[opp]};
                        mem_wdata = '{id: mem_rdata.id, price: mem_rdata.price,
                                      qty: mem_rdata.qty - fill};
                    end
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (qty_reg == 32'd0)
                    begin
                        m_tuser_next = KIND_DONE;
                    end
                    else if (rest)
                    begin
                        m_tuser_next = KIND_RESTED;
                    end
                    else
                    begin
                        m_tuser_next = KIND_FULL;
                    end
                    m_tdata_next = {qty_reg, lim_reg,
                                    (side_reg == SIDE_ASK) ? id_reg : 32'd0,
                                    (side_reg == SIDE_BID) ? id_reg : 32'd0};
                    idx_next = cnt_reg[own];
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we        = 1'b1;
                    cnt_next[own] = cnt_reg[own] + 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {own, phys(head_reg[own], idx_reg - 1'b1)};
                end
            end
            ST_INS_CMP:
            begin
                // walk back from the tail, moving worse orders one slot down
                mem_we = 1'b1;
                if (ahead)
                begin
                    cnt_next[own] = cnt_reg[own] + 1'b1;
                end
                else
                begin
                    mem_wdata = mem_rdata;
                    idx_next  = idx_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '{default: '0};
            head_reg     <= '{default: '0};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        side_reg    <= side_next;
        lim_reg     <= lim_next;
        qty_reg     <= qty_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_bid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[SIDE_BID] <= DEPTH_C)
        else $error("bid count beyond book depth");

    a_ask_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[SIDE_ASK] <= DEPTH_C)
        else $error("ask count beyond book depth");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && m_tvalid_reg) |-> m_tlast_reg)
        else $error("idle with a trade beat still pending");

    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> ((m_tuser_reg == KIND_TRADE) == !m_tlast_reg))
        else $error("trade kind and last flag disagree");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lome_pkg::*;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int EXP_DEPTH = 256;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] buyer;
        logic [31:0] seller;
        logic [31:0] price;
        logic [31:0] qty;
        logic        last;
    } fill_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    // book mirror, entry 0 is the best on each side
    logic [31:0] book_id [2][DEPTH];
    logic [31:0] book_px [2][DEPTH];
    logic [31:0] book_qty[2][DEPTH];
    int          book_cnt[2];

    // expected results, kept in a ring
    fill_t exp_buf[EXP_DEPTH];
    int    exp_wr;
    int    exp_rd;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    mismatches;
    int    results_seen;
    int    orders_sent;
    int    trades_seen;
    int    full_seen;
    longint cycles;

    limit_order_matching_engine_unit #(.BOOK_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    // append one expected result
    function automatic void exp_put(fill_t f);
        exp_buf[exp_wr % EXP_DEPTH] = f;
        exp_wr++;
    endfunction

    // take the oldest expected result
    function automatic fill_t exp_take();
        fill_t f;
        f = exp_buf[exp_rd % EXP_DEPTH];
        exp_rd++;
        return f;
    endfunction

    // remove the head of one side
    function automatic void pop_head(int sd);
        for (int i = 1; i < book_cnt[sd]; i++)
        begin
            book_id[sd][i-1]  = book_id[sd][i];
            book_px[sd][i-1]  = book_px[sd][i];
            book_qty[sd][i-1] = book_qty[sd][i];
        end
        book_cnt[sd]--;
    endfunction

    // match one order against the mirror and queue the expected fills
    function automatic void match_order(logic [31:0] oid, logic sd, logic [31:0] lim,
                                        logic [31:0] q);
        int    opp;
        int    own;
        int    n;
        int    pos;
        logic [31:0] rp;
        logic [31:0] fq;
        bit    crosses;
        bit    ahead;
        fill_t f;
        opp = (sd == SIDE_BID) ? 1 : 0;
        own = (sd == SIDE_BID) ? 0 : 1;
        n = 0;
        while (q != 0 && book_cnt[opp] > 0 && n < DEPTH)
        begin
            rp = book_px[opp][0];
            crosses = (sd == SIDE_BID) ? (rp <= lim) : (rp >= lim);
            if (!crosses)
                break;
            fq = (q < book_qty[opp][0]) ? q : book_qty[opp][0];
            f.kind   = KIND_TRADE;
            f.buyer  = (sd == SIDE_BID) ? oid : book_id[opp][0];
            f.seller = (sd == SIDE_BID) ? book_id[opp][0] : oid;
            f.price  = rp;
            f.qty    = fq;
            f.last   = 1'b0;
            exp_put(f);
            n++;
            q -= fq;
            book_qty[opp][0] -= fq;
            if (book_qty[opp][0] == 0)
                pop_head(opp);
        end
        if (q == 0)
            f.kind = KIND_DONE;
        else if (book_cnt[own] < DEPTH)
        begin
            pos = 0;
            while (pos < book_cnt[own])
            begin
                ahead = (sd == SIDE_BID) ? (book_px[own][pos] >= lim)
                                         : (book_px[own][pos] <= lim);
                if (!ahead)
                    break;
                pos++;
            end
            for (int i = book_cnt[own]; i > pos; i--)
            begin
                book_id[own][i]  = book_id[own][i-1];
                book_px[own][i]  = book_px[own][i-1];
                book_qty[own][i] = book_qty[own][i-1];
            end
            book_id[own][pos]  = oid;
            book_px[own][pos]  = lim;
            book_qty[own][pos] = q;
            book_cnt[own]++;
            f.kind = KIND_RESTED;
        end
        else
            f.kind = KIND_FULL;
        f.buyer  = (sd == SIDE_BID) ? oid : 32'd0;
        f.seller = (sd == SIDE_BID) ? 32'd0 : oid;
        f.price  = lim;
        f.qty    = q;
        f.last   = 1'b1;
        exp_put(f);
    endfunction

    // send one order beat; valid drops only while the sender idles
    task automatic send_order(logic [31:0] oid, logic sd, logic [31:0] lim, logic [31:0] q);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q, lim, oid};
        s_tuser  <= sd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        match_order(oid, sd, lim, q);
        orders_sent++;
        @(negedge clk);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        fill_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser == KIND_TRADE)
                trades_seen++;
            if (m_tuser == KIND_FULL)
                full_seen++;
            if (exp_wr == exp_rd)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat kind %0d data %h", m_tuser, m_tdata);
            end
            else
            begin
                e = exp_take();
                if (m_tuser !== e.kind || m_tdata[31:0] !== e.buyer
                    || m_tdata[63:32] !== e.seller || m_tdata[95:64] !== e.price
                    || m_tdata[127:96] !== e.qty || m_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d buy %h sell %h px %h qty %h last %b, got kind %0d buy %h sell %h px %h qty %h last %b",
                                 e.kind, e.buyer, e.seller, e.price, e.qty, e.last,
                                 m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                                 m_tdata[127:96], m_tlast);
                end
            end
        end
    end

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    // extremes of fields, zero quantity, sweeps over several levels
    task automatic test_directed();
        send_order(32'hFFFF_FFFF, SIDE_BID, 32'd0, 32'd0);
        send_order(32'd1, SIDE_ASK, 32'hFFFF_FFFF, 32'd0);
        send_order(32'd2, SIDE_BID, 32'd100, 32'd10);
        send_order(32'd3, SIDE_BID, 32'd100, 32'd5);
        send_order(32'd4, SIDE_BID, 32'd101, 32'd7);
        send_order(32'd5, SIDE_ASK, 32'd102, 32'd3);
        send_order(32'd6, SIDE_ASK, 32'd100, 32'd12);
        send_order(32'd7, SIDE_ASK, 32'd50, 32'd100);
        send_order(32'd8, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(32'd9, SIDE_ASK, 32'd0, 32'hFFFF_FFFF);
        send_order(32'd10, SIDE_BID, 32'hFFFF_FFFF, 32'd1);
        send_order(32'hAAAA_5555, SIDE_ASK, 32'h5555_AAAA, 32'hAAAA_5555);
        send_order(32'h5555_AAAA, SIDE_BID, 32'hAAAA_5555, 32'h5555_AAAA);
        send_order(32'd11, SIDE_ASK, 32'd0, 32'hFFFF_FFFF);
        send_order(32'd12, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
    endtask

    // fill the ask side, overflow it, sweep it with one big buy, then do the same on the bid side with one big sell
    task automatic test_book_full();
        for (int i = 0; i < DEPTH + 3; i++)
            send_order(32'h100 + i, SIDE_ASK, 32'd1000 + $urandom_range(7), 32'd1 + i);
        send_order(32'h200, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(32'h201, SIDE_ASK, 32'd5, 32'd1);
        for (int i = 0; i < DEPTH + 2; i++)
            send_order(32'h300 + i, SIDE_BID, 32'd10 + $urandom_range(3), 32'd2);
        send_order(32'h400, SIDE_ASK, 32'd0, 32'hFFFF_FFFF);
        drain_results();
    endtask

    // random orders near a mid price, with a little wide-range noise
    task automatic test_random(int count);
        logic [31:0] px;
        logic [31:0] q;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                px = $urandom;
                q  = $urandom;
            end
            else
            begin
                px = 32'd1000 + $urandom_range(20);
                q  = ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(1, 40);
            end
            send_order($urandom, $urandom_range(1), px, q);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cycles = 0;
        exp_wr = 0;
        exp_rd = 0;
        mismatches = 0;
        results_seen = 0;
        orders_sent = 0;
        trades_seen = 0;
        full_seen = 0;
        book_cnt[0] = 0;
        book_cnt[1] = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_book_full();
        test_random(90);
        send_idle_pct = 64;
        test_random(80);
        send_idle_pct = 0;
        recv_stall_pct = 64;
        test_random(80);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        test_random(80);

        $display("orders %0d, results %0d, trades %0d, book-full drops %0d",
                 orders_sent, results_seen, trades_seen, full_seen);
        $display("mismatch count %0d over four idle/stall phases", mismatches);
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> limit_order_matching_engine_unit.f
design/lome_pkg.sv
design/lome_book_ram.sv
design/limit_order_matching_engine_unit.sv
test/tb_top.sv
